>>> rtl/core/ifd_pkg.sv
package ifd_pkg;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 4;
  localparam int FS_W     = 12;
  localparam int RAW_W    = 16;
  localparam int AXIS_W   = 28;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 8;
  localparam int DATA_BYTES = 7;

  localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;
  localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FS = 8'd2;

  localparam logic [FS_W-1:0] ACCEL_FS_RESET = 12'd16;
  localparam logic [FS_W-1:0] RATE_FS_RESET  = 12'd2000;
  localparam logic [FS_W-1:0] ANGLE_FS_RESET = 12'd180;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  // One decoded frame as it waits between the front and the back.
  typedef struct packed {
    kind_t                   kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [FS_W-1:0] accel_fs;
    logic [FS_W-1:0] rate_fs;
    logic [FS_W-1:0] angle_fs;
  } fs_cfg_t;

endpackage

>>> rtl/core/ifd_front.sv
module ifd_front import ifd_pkg::*; #(
  parameter int FRAME_LEN = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  input  q_stat_t           q_stat,
  output logic              push,
  output frame_rec_t        push_rec
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);

  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [BYTE_W-1:0] frame_bytes [DATA_BYTES];
  logic [BYTE_W-1:0] cur_bytes   [DATA_BYTES];
  logic              accept;
  logic              in_frame;
  logic              last_byte;
  logic              store_en;
  logic [2:0]        store_idx;
  logic              type_ok;
  kind_t             kind;

  assign in_frame  = (byte_count != '0);
  assign last_byte = in_frame && (byte_count == LAST_CNT);
  // Only the beat that closes a frame needs room in the queue.
  assign rx_ready  = !(last_byte && q_stat.full);
  assign accept    = rx_valid && rx_ready;
  assign store_en  = in_frame && (byte_count <= CNT_W'(DATA_BYTES));
  assign store_idx = byte_count[2:0] - 3'd1;

  // Frame bytes as they stand after this beat, so a short frame can decode
  // on the same beat that writes its last data byte.
  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      cur_bytes[i] = (store_en && (store_idx == 3'(i))) ? rx_byte : frame_bytes[i];
    end
  end

  always_comb begin
    type_ok = 1'b1;
    kind    = KIND_ACCEL;
    unique case (cur_bytes[0])
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_RATE:  kind = KIND_RATE;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    type_ok = 1'b0;
    endcase
  end

  always_comb begin
    byte_count_next = byte_count;
    if (!in_frame) begin
      if (rx_byte == HDR_BYTE) begin
        byte_count_next = CNT_W'(1);
      end
    end else if (last_byte) begin
      byte_count_next = '0;
    end else begin
      byte_count_next = byte_count + CNT_W'(1);
    end
  end

  assign push           = accept && last_byte && type_ok;
  assign push_rec.kind  = kind;
  assign push_rec.raw_x = $signed({cur_bytes[2], cur_bytes[1]});
  assign push_rec.raw_y = $signed({cur_bytes[4], cur_bytes[3]});
  assign push_rec.raw_z = $signed({cur_bytes[6], cur_bytes[5]});

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      frame_bytes[store_idx] <= rx_byte;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count < CNT_W'(FRAME_LEN))
    else $error("frame byte count ran past the frame length");

endmodule

>>> rtl/core/ifd_queue.sv
module ifd_queue import ifd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  input  logic       pop,
  output frame_rec_t pop_rec,
  output q_stat_t    q_stat
);

  localparam int Q_DEPTH = 2;

  frame_rec_t  entries [Q_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign q_stat.full  = (count == 2'(Q_DEPTH));
  assign q_stat.empty = (count == 2'd0);
  assign pop_rec      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("frame queue read while empty");

endmodule

>>> rtl/core/ifd_back.sv
module ifd_back import ifd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  fs_cfg_t                  cfg,
  input  q_stat_t                  q_stat,
  input  frame_rec_t               pop_rec,
  output logic                     pop,
  output logic                     sample_valid,
  input  logic                     sample_ready,
  output logic [KIND_W-1:0]        sample_kind,
  output logic signed [AXIS_W-1:0] axis_x,
  output logic signed [AXIS_W-1:0] axis_y,
  output logic signed [AXIS_W-1:0] axis_z
);

  logic [FS_W-1:0]          fs_sel;
  logic signed [FS_W:0]     fs_s;
  logic signed [AXIS_W:0]   prod_x;
  logic signed [AXIS_W:0]   prod_y;
  logic signed [AXIS_W:0]   prod_z;

  assign pop = !q_stat.empty && (!sample_valid || sample_ready);

  always_comb begin
    unique case (pop_rec.kind)
      KIND_ACCEL: fs_sel = cfg.accel_fs;
      KIND_RATE:  fs_sel = cfg.rate_fs;
      KIND_ANGLE: fs_sel = cfg.angle_fs;
      default:    fs_sel = '0;
    endcase
  end

  assign fs_s   = $signed({1'b0, fs_sel});
  assign prod_x = pop_rec.raw_x * fs_s;
  assign prod_y = pop_rec.raw_y * fs_s;
  assign prod_z = pop_rec.raw_z * fs_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (pop) begin
      sample_valid <= 1'b1;
    end else if (sample_ready) begin
      sample_valid <= 1'b0;
    end
  end

  // The product of a 16-bit raw value and a 12-bit full scale always fits 28 bits.
  always_ff @(posedge clk) begin
    if (pop) begin
      sample_kind <= pop_rec.kind;
      axis_x      <= prod_x[AXIS_W-1:0];
      axis_y      <= prod_y[AXIS_W-1:0];
      axis_z      <= prod_z[AXIS_W-1:0];
    end
  end

  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> sample_valid)
    else $error("dequeued frame did not reach the output register");

endmodule

>>> rtl/core/imu_frame_decoder.sv
// Serial IMU frame decoder. One received byte is taken per beat on rx, at up
// to one beat per clock. Bytes outside a frame are dropped until the 0x55
// header; the frame closes on its FRAME_LEN-th byte, header included, and a
// frame of type 0x51, 0x52 or 0x53 yields one sample beat with the three
// axis values multiplied by the matching full-scale register (Q.15, value /
// 32768). The trailing bytes and the checksum are not checked. Closed frames
// wait in a two-entry queue ahead of the multiply stage, which registers a
// queued frame once the output register is free; rx stalls only when the
// closing byte of a frame arrives while that queue is full. The user must
// write the full-scale registers through cfg_we/cfg_index/cfg_data only
// while idle (the block does not enforce it); indexes above 2 are ignored.
module imu_frame_decoder import ifd_pkg::*; #(
  parameter int FRAME_LEN = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rx_valid,
  output logic                     rx_ready,
  input  logic [BYTE_W-1:0]        rx_byte,
  output logic                     sample_valid,
  input  logic                     sample_ready,
  output logic [KIND_W-1:0]        sample_kind,
  output logic signed [AXIS_W-1:0] axis_x,
  output logic signed [AXIS_W-1:0] axis_y,
  output logic signed [AXIS_W-1:0] axis_z,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [FS_W-1:0]          cfg_data
);

  fs_cfg_t    cfg;
  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  frame_rec_t push_rec;
  frame_rec_t pop_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_fs <= ACCEL_FS_RESET;
      cfg.rate_fs  <= RATE_FS_RESET;
      cfg.angle_fs <= ANGLE_FS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ACCEL_FS) begin
        cfg.accel_fs <= cfg_data;
      end
      if (cfg_index == REG_RATE_FS) begin
        cfg.rate_fs <= cfg_data;
      end
      if (cfg_index == REG_ANGLE_FS) begin
        cfg.angle_fs <= cfg_data;
      end
    end
  end

  ifd_front #(
    .FRAME_LEN(FRAME_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  ifd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  ifd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .pop_rec      (pop_rec),
    .pop          (pop),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_kind  (sample_kind),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z)
  );

endmodule
